### src/izhikevich_neuron_euler_step_core_macros.svh
// Assertion macros for the Izhikevich neuron core.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef IZHIKEVICH_NEURON_EULER_STEP_CORE_MACROS_SVH
`define IZHIKEVICH_NEURON_EULER_STEP_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define IZH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define IZH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define IZH_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define IZH_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/izh_pkg.sv
// Types, codes and the micro-program of the Izhikevich neuron core.
// No dependencies.
package izh_pkg;

    // bits of the multiplier operand consumed per cycle
    localparam int MUL_DIGIT = 4;

    typedef struct packed {
        logic               action;
        logic signed [31:0] input_current;
    } t_in_item;

    typedef struct packed {
        logic               spiked;
        logic signed [31:0] potential_out;
        logic signed [31:0] recovery_out;
    } t_out_item;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PARAM_A   = 3'd0;
    localparam t_cfg_idx CFG_PARAM_B   = 3'd1;
    localparam t_cfg_idx CFG_PARAM_C   = 3'd2;
    localparam t_cfg_idx CFG_PARAM_D   = 3'd3;
    localparam t_cfg_idx CFG_THRESHOLD = 3'd4;
    localparam t_cfg_idx CFG_STEP_SIZE = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_MFIN
    } t_state;

    typedef enum logic [2:0] {
        UOP_MUL,
        UOP_ADD,
        UOP_SUB,
        UOP_END,
        UOP_END_INIT
    } t_kind;

    typedef enum logic [3:0] {
        SRC_V,
        SRC_U,
        SRC_T1,
        SRC_T2,
        SRC_T3,
        SRC_CUR,
        SRC_A,
        SRC_B,
        SRC_C,
        SRC_D,
        SRC_DT,
        SRC_K04,
        SRC_K5,
        SRC_K140
    } t_src;

    typedef enum logic [1:0] {
        DST_T1,
        DST_T2,
        DST_T3
    } t_dst;

    typedef struct packed {
        t_kind kind;
        t_src  src_a;
        t_src  src_b;
        t_dst  dst;
    } t_uop;

    typedef logic [4:0] t_pc;
    localparam t_pc PC_STEP = 5'd0;
    localparam t_pc PC_INIT = 5'd16;

    // T1 builds dv then v+dv*dt, T2 builds du then u+du*dt, T3 holds the new u plus d
    function automatic t_uop uop_decode(input t_pc pc);
        t_uop u;
        case (pc)
            5'd0:           u = '{UOP_MUL, SRC_K04, SRC_V,    DST_T1};
            5'd1:           u = '{UOP_MUL, SRC_T1,  SRC_V,    DST_T1};
            5'd2:           u = '{UOP_MUL, SRC_K5,  SRC_V,    DST_T2};
            5'd3:           u = '{UOP_ADD, SRC_T1,  SRC_T2,   DST_T1};
            5'd4:           u = '{UOP_ADD, SRC_T1,  SRC_K140, DST_T1};
            5'd5:           u = '{UOP_SUB, SRC_T1,  SRC_U,    DST_T1};
            5'd6:           u = '{UOP_ADD, SRC_T1,  SRC_CUR,  DST_T1};
            5'd7:           u = '{UOP_MUL, SRC_B,   SRC_V,    DST_T2};
            5'd8:           u = '{UOP_SUB, SRC_T2,  SRC_U,    DST_T2};
            5'd9:           u = '{UOP_MUL, SRC_A,   SRC_T2,   DST_T2};
            5'd10:          u = '{UOP_MUL, SRC_T1,  SRC_DT,   DST_T1};
            5'd11:          u = '{UOP_MUL, SRC_T2,  SRC_DT,   DST_T2};
            5'd12:          u = '{UOP_ADD, SRC_V,   SRC_T1,   DST_T1};
            5'd13:          u = '{UOP_ADD, SRC_U,   SRC_T2,   DST_T2};
            5'd14:          u = '{UOP_ADD, SRC_T2,  SRC_D,    DST_T3};
            5'd15:          u = '{UOP_END, SRC_V,   SRC_V,    DST_T1};
            PC_INIT:        u = '{UOP_MUL, SRC_B,   SRC_C,    DST_T2};
            PC_INIT + 5'd1: u = '{UOP_END_INIT, SRC_V, SRC_V, DST_T1};
            default:        u = '{UOP_END_INIT, SRC_V, SRC_V, DST_T1};
        endcase
        return u;
    endfunction

endpackage

### src/izhikevich_neuron_euler_step_core.sv
// Izhikevich neuron core: one forward-Euler step or an init per request.
// Depends on izh_pkg and izhikevich_neuron_euler_step_core_macros.svh.

// One Izhikevich neuron in signed fixed point (VALUE_WIDTH bits, FRAC_BITS fraction bits,
// every sum and product saturated). A request with action 0 advances v and u by one Euler
// step, firing and resetting when v reaches the threshold; action 1 loads v = c, u = b*c.
// All products go through one shared multiplier that consumes MUL_DIGIT (4) bits of its
// second operand per cycle, one product at a time. The next request is taken in the cycle
// after the commit. o_in_stall stays high from acceptance until the result is committed,
// and the commit waits while the output register still holds a result that has not been
// taken. Write configuration only while no request is open.
`include "izhikevich_neuron_euler_step_core_macros.svh"

module izhikevich_neuron_euler_step_core #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  izh_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output izh_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  izh_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [23:0]        i_cfg_wdata
);
    import izh_pkg::*;

    localparam int VW   = VALUE_WIDTH;
    localparam int FB   = FRAC_BITS;
    localparam int DIG  = MUL_DIGIT;
    localparam int NDIG = (VW + DIG - 1) / DIG;
    localparam int YW   = NDIG * DIG;
    localparam int AW   = VW + YW;
    localparam int CW   = $clog2(NDIG);

    localparam longint MAXV64 = (longint'(1) <<< (VW - 1)) - 1;
    localparam longint MINV64 = -MAXV64 - 1;
    localparam longint ONE    = longint'(1) <<< FB;

    function automatic logic signed [VW-1:0] sat64(input logic signed [63:0] x);
        logic signed [VW-1:0] r;
        if (x > MAXV64) begin
            r = {1'b0, {(VW-1){1'b1}}};
        end else if (x < MINV64) begin
            r = {1'b1, {(VW-1){1'b0}}};
        end else begin
            r = x[VW-1:0];
        end
        return r;
    endfunction

    localparam logic signed [VW-1:0] K04   = sat64((ONE * 4 + 50) / 100);
    localparam logic signed [VW-1:0] K5    = sat64(ONE * 5);
    localparam logic signed [VW-1:0] K140  = sat64(ONE * 140);
    localparam logic signed [VW-1:0] A_RST = sat64((ONE * 2 + 50) / 100);
    localparam logic signed [VW-1:0] B_RST = sat64((ONE * 2 + 5) / 10);
    localparam logic signed [VW-1:0] C_RST = sat64(-65 * ONE);
    localparam logic signed [VW-1:0] D_RST = sat64(8 * ONE);
    localparam logic signed [VW-1:0] T_RST = sat64(30 * ONE);
    localparam logic signed [VW-1:0] S_RST = sat64(ONE);
    localparam logic signed [VW-1:0] V_RST = sat64(-65 * ONE);
    localparam logic signed [VW-1:0] U_RST = sat64(-13 * ONE);

    // configuration, held already saturated to the value range
    logic signed [VW-1:0] r_a, r_b, r_c, r_d, r_thr, r_dt;
    // neuron state and scratch
    logic signed [VW-1:0] r_v, r_u, r_t1, r_t2, r_t3, r_cur;

    t_state r_state, n_state;
    t_pc    r_pc;
    t_uop   w_uop;

    logic [VW-1:0]   r_mx;
    logic [YW-1:0]   r_my;
    logic [AW-1:0]   r_acc;
    logic [CW-1:0]   r_cnt;
    logic            r_neg;

    t_out_item r_out;
    logic      r_out_valid;

    logic w_in_accept, w_out_free;
    logic w_alu_wr, w_mul_load, w_mul_step, w_mul_wr, w_commit, w_pc_inc;

    logic signed [VW-1:0] w_opa, w_opb, w_alu, w_mres;
    logic signed [VW:0]   w_sum;
    logic [VW+DIG-1:0]    w_part;
    logic [AW:0]          w_q, w_q2;
    logic                 w_ovf;
    logic [VW-1:0]        w_qneg;
    logic                 w_spike;
    logic signed [VW-1:0] w_new_v, w_new_u;
    logic [63:0]          w_v_ext, w_u_ext;

    function automatic logic signed [VW-1:0] pick(input t_src s);
        logic signed [VW-1:0] r;
        case (s)
            SRC_V:    r = r_v;
            SRC_U:    r = r_u;
            SRC_T1:   r = r_t1;
            SRC_T2:   r = r_t2;
            SRC_T3:   r = r_t3;
            SRC_CUR:  r = r_cur;
            SRC_A:    r = r_a;
            SRC_B:    r = r_b;
            SRC_C:    r = r_c;
            SRC_D:    r = r_d;
            SRC_DT:   r = r_dt;
            SRC_K04:  r = K04;
            SRC_K5:   r = K5;
            SRC_K140: r = K140;
            default:  r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] x);
        return x[VW-1] ? (~x + {{(VW-1){1'b0}}, 1'b1}) : x;
    endfunction

    assign w_uop       = uop_decode(r_pc);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // operand select, follows every register that pick reads
    always_comb begin
        w_opa = pick(w_uop.src_a);
        w_opb = pick(w_uop.src_b);
    end

    // saturating adder
    always_comb begin
        if (w_uop.kind == UOP_SUB) begin
            w_sum = {w_opa[VW-1], w_opa} - {w_opb[VW-1], w_opb};
        end else begin
            w_sum = {w_opa[VW-1], w_opa} + {w_opb[VW-1], w_opb};
        end
        if (w_sum[VW] != w_sum[VW-1]) begin
            w_alu = w_sum[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else begin
            w_alu = w_sum[VW-1:0];
        end
    end

    // one digit of the magnitude product
    assign w_part = {{DIG{1'b0}}, r_mx} * {{VW{1'b0}}, r_my[DIG-1:0]};

    // floor of the signed product, then saturate
    always_comb begin
        w_q    = {1'b0, r_acc} >> FB;
        w_q2   = w_q + {{AW{1'b0}}, (r_neg && (|r_acc[FB-1:0]))};
        w_qneg = (~w_q2[VW-1:0]) + {{(VW-1){1'b0}}, 1'b1};
        if (r_neg) begin
            w_ovf  = (|w_q2[AW:VW]) || (w_q2[VW-1] && (|w_q2[VW-2:0]));
            w_mres = w_ovf ? {1'b1, {(VW-1){1'b0}}} : w_qneg;
        end else begin
            w_ovf  = |w_q2[AW:VW-1];
            w_mres = w_ovf ? {1'b0, {(VW-1){1'b1}}} : w_q2[VW-1:0];
        end
    end

    always_comb begin
        w_spike = 1'b0;
        w_new_v = r_c;
        w_new_u = r_t2;
        if (w_uop.kind == UOP_END) begin
            w_spike = (r_t1 >= r_thr);
            w_new_v = w_spike ? r_c : r_t1;
            w_new_u = w_spike ? r_t3 : r_t2;
        end
    end

    assign w_v_ext = {{(64-VW){w_new_v[VW-1]}}, w_new_v};
    assign w_u_ext = {{(64-VW){w_new_u[VW-1]}}, w_new_u};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (w_uop.kind)
                    UOP_MUL:              n_state = ST_MUL;
                    UOP_ADD, UOP_SUB:     n_state = ST_EXEC;
                    default: begin
                        if (w_out_free) begin
                            n_state = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_MUL: begin
                if (r_cnt == '0) begin
                    n_state = ST_MFIN;
                end
            end
            ST_MFIN: n_state = ST_EXEC;
            default: n_state = ST_IDLE;
        endcase
    end

    // control
    always_comb begin
        w_alu_wr   = 1'b0;
        w_mul_load = 1'b0;
        w_mul_step = 1'b0;
        w_mul_wr   = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            ST_EXEC: begin
                w_alu_wr   = (w_uop.kind == UOP_ADD) || (w_uop.kind == UOP_SUB);
                w_mul_load = (w_uop.kind == UOP_MUL);
                w_commit   = ((w_uop.kind == UOP_END) || (w_uop.kind == UOP_END_INIT))
                             && w_out_free;
            end
            ST_MUL:  w_mul_step = 1'b1;
            ST_MFIN: w_mul_wr   = 1'b1;
            default: ;
        endcase
        w_pc_inc = w_alu_wr || w_mul_wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_v         <= V_RST;
            r_u         <= U_RST;
            r_a         <= A_RST;
            r_b         <= B_RST;
            r_c         <= C_RST;
            r_d         <= D_RST;
            r_thr       <= T_RST;
            r_dt        <= S_RST;
        end else begin
            r_state <= n_state;

            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (w_commit) begin
                r_v <= w_new_v;
                r_u <= w_new_u;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PARAM_A:   r_a   <= sat64($signed({47'd0, i_cfg_wdata[16:0]}));
                    CFG_PARAM_B:   r_b   <= sat64($signed({47'd0, i_cfg_wdata[16:0]}));
                    CFG_PARAM_C:   r_c   <= sat64($signed({{40{i_cfg_wdata[23]}}, i_cfg_wdata}));
                    CFG_PARAM_D:   r_d   <= sat64($signed({{40{i_cfg_wdata[23]}}, i_cfg_wdata}));
                    CFG_THRESHOLD: r_thr <= sat64($signed({{40{i_cfg_wdata[23]}}, i_cfg_wdata}));
                    CFG_STEP_SIZE: r_dt  <= sat64($signed({47'd0, i_cfg_wdata[16:0]}));
                    default: ;
                endcase
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_pc  <= i_in_data.action ? PC_INIT : PC_STEP;
            r_cur <= sat64($signed({{32{i_in_data.input_current[31]}},
                                    i_in_data.input_current}));
        end else if (w_pc_inc) begin
            r_pc <= r_pc + 5'd1;
        end

        if (w_mul_load) begin
            r_mx  <= mag(w_opa);
            r_my  <= YW'(mag(w_opb));
            r_neg <= w_opa[VW-1] ^ w_opb[VW-1];
            r_acc <= '0;
            r_cnt <= CW'(NDIG - 1);
        end else if (w_mul_step) begin
            // add the digit into the top half, then shift the whole product right
            r_acc <= {{{DIG{1'b0}}, r_acc[AW-1:YW]} + w_part, r_acc[YW-1:DIG]};
            r_my  <= r_my >> DIG;
            r_cnt <= r_cnt - {{(CW-1){1'b0}}, 1'b1};
        end

        if (w_alu_wr || w_mul_wr) begin
            case (w_uop.dst)
                DST_T1:  r_t1 <= w_alu_wr ? w_alu : w_mres;
                DST_T2:  r_t2 <= w_alu_wr ? w_alu : w_mres;
                DST_T3:  r_t3 <= w_alu_wr ? w_alu : w_mres;
                default: ;
            endcase
        end

        if (w_commit) begin
            r_out.spiked        <= w_spike;
            r_out.potential_out <= w_v_ext[31:0];
            r_out.recovery_out  <= w_u_ext[31:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `IZH_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_in_accept, r_state == ST_EXEC)
    `IZH_ASSERT_SAME(a_mul_uop, i_clk, i_rst_n, r_state == ST_MUL, w_uop.kind == UOP_MUL)
    `IZH_ASSERT_SAME(a_mul_drained, i_clk, i_rst_n, r_state == ST_MFIN, r_my == '0)
    `IZH_ASSERT_NEXT(a_valid_from_commit, i_clk, i_rst_n, !r_out_valid && !w_commit, !r_out_valid)

endmodule
